[src/r2fft_pkg.sv]
// Shared types, constants and functions of the radix-2 FFT / IFFT core.
// Holds the twiddle table builder used by the butterfly datapath.
// No dependencies.
package r2fft_pkg;

   localparam int MAX_LOG2_SIZE = 10;
   localparam int SAMPLE_WIDTH  = 16;
   localparam int TWIDDLE_WIDTH = 16;
   localparam int BIN_WIDTH     = 27;
   localparam int MEM_DEPTH     = 1 << MAX_LOG2_SIZE;
   localparam int ADDR_WIDTH    = MAX_LOG2_SIZE;
   localparam int CNT_WIDTH     = MAX_LOG2_SIZE + 1;
   localparam int BFLY_WIDTH    = MAX_LOG2_SIZE - 1;
   localparam int WORD_WIDTH    = 2 * BIN_WIDTH;
   localparam int PHASE_BITS    = 18;
   localparam int TW_DEPTH      = 1 << (MAX_LOG2_SIZE - 2);
   localparam int TW_RWIDTH     = MAX_LOG2_SIZE - 2;
   localparam int MAG_WIDTH     = TWIDDLE_WIDTH + 1;
   localparam int PROD_WIDTH    = BIN_WIDTH + TWIDDLE_WIDTH;
   localparam int ACC_WIDTH     = PROD_WIDTH + 1;
   localparam int TR_WIDTH      = ACC_WIDTH - (TWIDDLE_WIDTH - 1);
   localparam int SUM_WIDTH     = TR_WIDTH + 1;
   localparam int OUT_WIDTH     = BIN_WIDTH + 2;
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   // register indexes on the configuration port
   localparam logic REG_LOG2_SIZE = 1'b0;
   localparam logic REG_INVERSE   = 1'b1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef logic [2*MAG_WIDTH-1:0] tw_rom_type [TW_DEPTH];

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_RDA  = 7'b0000010,
      ST_RDC  = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_SUM  = 7'b0010000,
      ST_WRA  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic tw_en;
      logic mul_en;
   } bfly_ctl_type;

   // shift-and-subtract quotient, evaluated only while the table is built
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned q, rem;
      q   = 0;
      rem = 0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem  = rem - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Q30 Taylor series on a quarter wave, quantized cosine and sine magnitudes
   function automatic tw_rom_type build_tw_rom();
      tw_rom_type rom;
      longint unsigned r, x, x2, ts, tc;
      longint ss, cs, c0, s0;
      int sh;
      sh = 30 - (TWIDDLE_WIDTH - 1);
      for (int i = 0; i < TW_DEPTH; i++) begin
         r  = longint'(i) << (PHASE_BITS - 2 - TW_RWIDTH);
         x  = (r * PI_Q30 + (64'd1 << (PHASE_BITS - 2))) >> (PHASE_BITS - 1);
         x2 = (x * x) >> 30;
         ts = x;
         tc = 64'd1 << 30;
         ss = longint'(x);
         cs = longint'(tc);
         for (int k = 1; k <= 12; k++) begin
            ts = udiv64((ts * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
            tc = udiv64((tc * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if ((k & 1) == 1) begin
               ss = ss - longint'(ts);
               cs = cs - longint'(tc);
            end else begin
               ss = ss + longint'(ts);
               cs = cs + longint'(tc);
            end
         end
         if (cs < 0) cs = 0;
         if (ss < 0) ss = 0;
         c0 = (cs + (longint'(1) << (sh - 1))) >>> sh;
         s0 = (ss + (longint'(1) << (sh - 1))) >>> sh;
         rom[i] = {c0[MAG_WIDTH-1:0], s0[MAG_WIDTH-1:0]};
      end
      return rom;
   endfunction

   localparam tw_rom_type TW_ROM = build_tw_rom();

   function automatic logic [ADDR_WIDTH-1:0] bit_rev(input logic [ADDR_WIDTH-1:0] v);
      logic [ADDR_WIDTH-1:0] r;
      for (int b = 0; b < ADDR_WIDTH; b++) r[b] = v[ADDR_WIDTH-1-b];
      return r;
   endfunction

   // clamp to the signed bin range
   function automatic logic [BIN_WIDTH-1:0] sat_bin(input logic signed [SUM_WIDTH-1:0] v);
      logic signed [SUM_WIDTH-1:0] hi, lo;
      hi = SUM_WIDTH'((longint'(1) << (BIN_WIDTH - 1)) - 1);
      lo = -SUM_WIDTH'(longint'(1) << (BIN_WIDTH - 1));
      if (v > hi) return hi[BIN_WIDTH-1:0];
      if (v < lo) return lo[BIN_WIDTH-1:0];
      return v[BIN_WIDTH-1:0];
   endfunction

endpackage

[src/r2fft_bfly.sv]
// Butterfly datapath: twiddle lookup, complex multiply, saturating sum and difference.
// Depends on r2fft_pkg.
module r2fft_bfly (
   input  logic                                  clock,
   input  r2fft_pkg::bfly_ctl_type               ctl,
   input  logic [r2fft_pkg::BFLY_WIDTH-1:0]      tw_idx,
   input  logic [r2fft_pkg::WORD_WIDTH-1:0]      a_data,
   input  logic [r2fft_pkg::WORD_WIDTH-1:0]      c_data,
   output logic [r2fft_pkg::WORD_WIDTH-1:0]      sum_data,
   output logic [r2fft_pkg::WORD_WIDTH-1:0]      diff_data
);

   localparam int BW = r2fft_pkg::BIN_WIDTH;
   localparam int MW = r2fft_pkg::MAG_WIDTH;
   localparam int TW = r2fft_pkg::TWIDDLE_WIDTH;
   localparam int PW = r2fft_pkg::PROD_WIDTH;
   localparam int AW = r2fft_pkg::ACC_WIDTH;
   localparam int RW = r2fft_pkg::TW_RWIDTH;

   logic [2*MW-1:0]          rom_word;
   logic [MW-1:0]            c0, s0, c_sat, s_sat, maxp;
   logic signed [MW-1:0]     wr_full, wi_full;
   logic signed [TW-1:0]     wr_ff, wi_ff, wr_in, wi_in;
   logic                     jz_ff, jz_in;
   logic signed [BW-1:0]     cre_ff, cim_ff;
   logic signed [PW-1:0]     prr_ff, pii_ff, pri_ff, pir_ff;
   logic signed [AW-1:0]     accr, acci;
   logic signed [r2fft_pkg::TR_WIDTH-1:0]  tr, ti;
   logic signed [BW-1:0]     are, aim;

   // look up quarter-wave magnitudes and fold into the first half circle
   always_comb begin
      rom_word = r2fft_pkg::TW_ROM[tw_idx[RW-1:0]];
      c0       = rom_word[2*MW-1:MW];
      s0       = rom_word[MW-1:0];
      maxp     = MW'((1 << (TW - 1)) - 1);
      c_sat    = (c0 > maxp) ? maxp : c0;
      s_sat    = (s0 > maxp) ? maxp : s0;
      if (tw_idx[RW]) begin
         wr_full = -$signed(s0);
         wi_full = -$signed(c_sat);
      end else begin
         wr_full = $signed(c_sat);
         wi_full = -$signed(s_sat);
      end
      wr_in = wr_full[TW-1:0];
      wi_in = wi_full[TW-1:0];
      jz_in = (tw_idx == '0);
   end

   // hold twiddle, then register the four partial products
   always_ff @(posedge clock) begin
      if (ctl.tw_en) begin
         wr_ff <= wr_in;
         wi_ff <= wi_in;
         jz_ff <= jz_in;
      end
      if (ctl.mul_en) begin
         cre_ff <= $signed(c_data[2*BW-1:BW]);
         cim_ff <= $signed(c_data[BW-1:0]);
         prr_ff <= $signed(c_data[2*BW-1:BW]) * wr_ff;
         pii_ff <= $signed(c_data[BW-1:0]) * wi_ff;
         pri_ff <= $signed(c_data[2*BW-1:BW]) * wi_ff;
         pir_ff <= $signed(c_data[BW-1:0]) * wr_ff;
      end
   end

   // round the product to nearest, then add and subtract with saturation
   always_comb begin
      accr = AW'(prr_ff) - AW'(pii_ff) + AW'(1 << (TW - 2));
      acci = AW'(pri_ff) + AW'(pir_ff) + AW'(1 << (TW - 2));
      if (jz_ff) begin
         tr = r2fft_pkg::TR_WIDTH'(cre_ff);
         ti = r2fft_pkg::TR_WIDTH'(cim_ff);
      end else begin
         tr = accr[AW-1:TW-1];
         ti = acci[AW-1:TW-1];
      end
      are = $signed(a_data[2*BW-1:BW]);
      aim = $signed(a_data[BW-1:0]);
      sum_data  = {r2fft_pkg::sat_bin(r2fft_pkg::SUM_WIDTH'(are) + r2fft_pkg::SUM_WIDTH'(tr)),
                   r2fft_pkg::sat_bin(r2fft_pkg::SUM_WIDTH'(aim) + r2fft_pkg::SUM_WIDTH'(ti))};
      diff_data = {r2fft_pkg::sat_bin(r2fft_pkg::SUM_WIDTH'(are) - r2fft_pkg::SUM_WIDTH'(tr)),
                   r2fft_pkg::sat_bin(r2fft_pkg::SUM_WIDTH'(aim) - r2fft_pkg::SUM_WIDTH'(ti))};
   end

endmodule

[src/radix2_fft_ifft_core.sv]
// Top level of the radix-2 decimation-in-time FFT / IFFT core.
// Holds the work memory, the sequencer and the APB register file; uses r2fft_pkg, r2fft_bfly.
//
// A load request (opcode 0) writes the sample at its bit-reversed address, so no reorder
// pass is needed. The last sample of a frame of N = 2^L starts the transform: busy stays
// high while its (N/2) * L butterflies run through the work memory with its one read and
// one write port, each as the steps read a, read c, multiply, write c, write a. A read
// request (opcode 1) holds busy while its bin is returned; rsp_valid marks the bin for
// exactly one cycle, the cycle right after the request is accepted, and the receiver must
// take it then.
module radix2_fft_ifft_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_opcode,
   input  logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] req_sample_real,
   input  logic signed [r2fft_pkg::SAMPLE_WIDTH-1:0] req_sample_imag,
   output logic                                   rsp_valid,
   output logic signed [r2fft_pkg::BIN_WIDTH-1:0] rsp_bin_real,
   output logic signed [r2fft_pkg::BIN_WIDTH-1:0] rsp_bin_imag,
   output logic                                   rsp_last_bin,
   output logic                                   rsp_status,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [2:0]                             paddr,
   input  logic [31:0]                            pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);

   localparam int BW = r2fft_pkg::BIN_WIDTH;
   localparam int AW = r2fft_pkg::ADDR_WIDTH;
   localparam int CW = r2fft_pkg::CNT_WIDTH;
   localparam int FW = r2fft_pkg::BFLY_WIDTH;
   localparam int OW = r2fft_pkg::OUT_WIDTH;
   localparam int MAXL = r2fft_pkg::MAX_LOG2_SIZE;

   r2fft_pkg::state_type state_ff, state_in;
   logic [3:0]      log2_ff, log2_in;
   logic            inv_ff, inv_in;
   logic [CW-1:0]   load_cnt_ff, load_cnt_in;
   logic [CW-1:0]   rptr_ff, rptr_in;
   logic            ready_ff, ready_in;
   logic [3:0]      stage_ff, stage_in;
   logic [FW-1:0]   bfly_ff, bfly_in;
   logic            err_ff, err_in;
   logic            last_ff, last_in;

   logic [r2fft_pkg::WORD_WIDTH-1:0] mem [r2fft_pkg::MEM_DEPTH];
   logic [r2fft_pkg::WORD_WIDTH-1:0] rdata_ff, a_ff, wdata, sum_data, diff_data;
   logic [AW-1:0]   raddr, waddr;
   logic            wen;

   logic [3:0]      eff_l;
   logic [CW-1:0]   n_size;
   logic [AW-1:0]   half_mask, h_bit, bext, a_addr, c_addr;
   logic [FW-1:0]   tw_idx;
   logic [CW-1:0]   lc, lc_next;
   logic            accept, cfg_wr;
   logic signed [BW-1:0] load_re, load_im;
   r2fft_pkg::bfly_ctl_type ctl;

   logic            scale;
   logic signed [OW-1:0] vr, vi, rnd;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign accept = start && !busy;
   assign busy   = (state_ff != r2fft_pkg::ST_IDLE);

   // transform length and butterfly addressing
   always_comb begin
      eff_l     = (log2_ff > 4'(MAXL)) ? 4'(MAXL) : log2_ff;
      n_size    = CW'(1) << eff_l;
      h_bit     = AW'(1) << (stage_ff - 4'd1);
      half_mask = h_bit - AW'(1);
      bext      = AW'(bfly_ff);
      a_addr    = ((bext & ~half_mask) << 1) | (bext & half_mask);
      c_addr    = a_addr | h_bit;
      tw_idx    = FW'((bext & half_mask) << (4'(MAXL) - stage_ff));
      load_re   = BW'(req_sample_real);
      load_im   = inv_ff ? -BW'(req_sample_imag) : BW'(req_sample_imag);
      lc        = ready_ff ? '0 : load_cnt_ff;
      if (lc >= n_size) lc = '0;
      lc_next   = lc + CW'(1);
   end

   // sequencer and frame bookkeeping
   always_comb begin
      state_in    = state_ff;
      log2_in     = log2_ff;
      inv_in      = inv_ff;
      load_cnt_in = load_cnt_ff;
      rptr_in     = rptr_ff;
      ready_in    = ready_ff;
      stage_in    = stage_ff;
      bfly_in     = bfly_ff;
      err_in      = err_ff;
      last_in     = last_ff;
      raddr       = rptr_ff[AW-1:0];
      waddr       = r2fft_pkg::bit_rev(lc[AW-1:0]) >> (4'(MAXL) - eff_l);
      wdata       = {load_re, load_im};
      wen         = 1'b0;
      ctl         = '0;
      case (state_ff)
         r2fft_pkg::ST_IDLE: begin
            if (accept && req_opcode == r2fft_pkg::OP_LOAD) begin
               wen      = 1'b1;
               rptr_in  = '0;
               if (lc_next == n_size) begin
                  load_cnt_in = '0;
                  if (eff_l == 4'd0) begin
                     ready_in = 1'b1;
                  end else begin
                     ready_in = 1'b0;
                     stage_in = 4'd1;
                     bfly_in  = '0;
                     state_in = r2fft_pkg::ST_RDA;
                  end
               end else begin
                  load_cnt_in = lc_next;
                  ready_in    = 1'b0;
               end
            end else if (accept) begin
               state_in = r2fft_pkg::ST_OUT;
               if (!ready_ff || rptr_ff >= n_size) begin
                  err_in  = 1'b1;
                  last_in = 1'b0;
               end else begin
                  err_in  = 1'b0;
                  last_in = (rptr_ff == n_size - CW'(1));
                  if (rptr_ff + CW'(1) == n_size) begin
                     rptr_in  = '0;
                     ready_in = 1'b0;
                  end else begin
                     rptr_in = rptr_ff + CW'(1);
                  end
               end
            end else if (cfg_wr) begin
               if (paddr[2] == r2fft_pkg::REG_LOG2_SIZE) log2_in = pwdata[3:0];
               else inv_in = pwdata[0];
               load_cnt_in = '0;
               rptr_in     = '0;
               ready_in    = 1'b0;
            end
         end
         r2fft_pkg::ST_RDA: begin
            raddr    = a_addr;
            state_in = r2fft_pkg::ST_RDC;
         end
         r2fft_pkg::ST_RDC: begin
            raddr     = c_addr;
            ctl.tw_en = 1'b1;
            state_in  = r2fft_pkg::ST_MUL;
         end
         r2fft_pkg::ST_MUL: begin
            ctl.mul_en = 1'b1;
            state_in   = r2fft_pkg::ST_SUM;
         end
         r2fft_pkg::ST_SUM: begin
            wen      = 1'b1;
            waddr    = c_addr;
            wdata    = diff_data;
            state_in = r2fft_pkg::ST_WRA;
         end
         r2fft_pkg::ST_WRA: begin
            wen   = 1'b1;
            waddr = a_addr;
            wdata = sum_data;
            if (CW'(bfly_ff) == (n_size >> 1) - CW'(1)) begin
               bfly_in = '0;
               if (stage_ff == eff_l) begin
                  ready_in = 1'b1;
                  state_in = r2fft_pkg::ST_IDLE;
               end else begin
                  stage_in = stage_ff + 4'd1;
                  state_in = r2fft_pkg::ST_RDA;
               end
            end else begin
               bfly_in  = bfly_ff + FW'(1);
               state_in = r2fft_pkg::ST_RDA;
            end
         end
         r2fft_pkg::ST_OUT: begin
            state_in = r2fft_pkg::ST_IDLE;
         end
         default: state_in = r2fft_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= r2fft_pkg::ST_IDLE;
         log2_ff     <= 4'(MAXL);
         inv_ff      <= 1'b0;
         load_cnt_ff <= '0;
         rptr_ff     <= '0;
         ready_ff    <= 1'b0;
         stage_ff    <= 4'd1;
         bfly_ff     <= '0;
         err_ff      <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         log2_ff     <= log2_in;
         inv_ff      <= inv_in;
         load_cnt_ff <= load_cnt_in;
         rptr_ff     <= rptr_in;
         ready_ff    <= ready_in;
         stage_ff    <= stage_in;
         bfly_ff     <= bfly_in;
         err_ff      <= err_in;
         last_ff     <= last_in;
      end
   end

   // work memory, one read and one write port, registered read
   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
      if (state_ff == r2fft_pkg::ST_RDC) a_ff <= rdata_ff;
   end

   r2fft_bfly u_bfly (
      .clock     (clock),
      .ctl       (ctl),
      .tw_idx    (tw_idx),
      .a_data    (a_ff),
      .c_data    (rdata_ff),
      .sum_data  (sum_data),
      .diff_data (diff_data)
   );

   // inverse: conjugate and divide by N with round to nearest on the way out
   always_comb begin
      scale = inv_ff && (eff_l != 4'd0);
      vr    = OW'($signed(rdata_ff[2*BW-1:BW]));
      vi    = OW'($signed(rdata_ff[BW-1:0]));
      rnd   = '0;
      if (scale) begin
         rnd = OW'(1) << (eff_l - 4'd1);
         vr  = (vr + rnd) >>> eff_l;
         vi  = (-vi + rnd) >>> eff_l;
      end
   end

   assign rsp_valid    = (state_ff == r2fft_pkg::ST_OUT);
   assign rsp_bin_real = err_ff ? '0 : vr[BW-1:0];
   assign rsp_bin_imag = err_ff ? '0 : vi[BW-1:0];
   assign rsp_last_bin = last_ff;
   assign rsp_status   = err_ff;
   assign prdata = (paddr[2] == r2fft_pkg::REG_INVERSE) ? {31'd0, inv_ff} : {28'd0, log2_ff};

   // a read request yields its bin in the cycle after it is accepted
   assert property (@(posedge clock) disable iff (reset)
      accept && req_opcode == r2fft_pkg::OP_READ |=> rsp_valid)
      else $error("read request without response");

   // responses never come back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back responses");

   // no finished frame while a butterfly is in its multiply step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == r2fft_pkg::ST_MUL) |-> !ready_ff)
      else $error("frame ready during transform");

   // butterfly index stays inside the current length
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == r2fft_pkg::ST_WRA) |-> (CW'(bfly_ff) < (n_size >> 1)))
      else $error("butterfly index out of range");

   // a failed read reports no last bin
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_last_bin)
      else $error("last flag on failed read");

endmodule
